// ===== src/mtidr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtidr_pkg: shared types and constants for the match table
// Request and status codes, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtidr_pkg;

    localparam int KEY_W       = 31;
    localparam int POS_W       = 3;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_REPLACE = 2'd2,
        REQ_QUERY   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_INSERT,
        EMIT_MID,
        EMIT_FINAL
    } emit_t;

    typedef struct packed {
        logic  load_req;
        logic  rd_en;
        logic  idx_inc;
        logic  apply;
        logic  capture;
        logic  insert_write;
        emit_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic is_insert;
        logic slot_free;
        logic key_hit;
        logic pend_valid;
        logic cnt_full;
        logic idx_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/mtidr_ram.sv =====
// ----------------------------------------------------------------------------
// mtidr_ram: generic single-port RAM
// One address per cycle, with a write, a read or both, and a registered read port.
// ----------------------------------------------------------------------------
module mtidr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mtidr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtidr_ctrl: request sequencer
// Takes a request, walks the slots one at a time and decides when a result
// goes out, stalling the walk while a due result finds the output register occupied.
// ----------------------------------------------------------------------------
module mtidr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mtidr_pkg::dp_status_t sts,
    output mtidr_pkg::dp_cmd_t    cmd
);

    mtidr_pkg::state_t state_reg, state_next;

    logic report;
    logic check_stall;
    logic insert_done;

    // A match that will be reported pushes out the previous pending one.
    always_comb begin
        report      = sts.key_hit && !sts.cnt_full;
        insert_done = sts.is_insert && sts.slot_free && sts.out_free;
        check_stall = sts.is_insert
                    ? (sts.slot_free && !sts.out_free)
                    : (report && sts.pend_valid && !sts.out_free);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mtidr_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = mtidr_pkg::S_READ;
                end
            end
            mtidr_pkg::S_READ: begin
                state_next = sts.invalid ? mtidr_pkg::S_FINISH : mtidr_pkg::S_CHECK;
            end
            mtidr_pkg::S_CHECK: begin
                if (insert_done) begin
                    state_next = mtidr_pkg::S_IDLE;
                end else if (!check_stall) begin
                    state_next = sts.idx_last ? mtidr_pkg::S_FINISH : mtidr_pkg::S_READ;
                end
            end
            mtidr_pkg::S_FINISH: begin
                if (sts.out_free) begin
                    state_next = mtidr_pkg::S_IDLE;
                end
            end
            default: state_next = mtidr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.emit = mtidr_pkg::EMIT_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            mtidr_pkg::S_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            mtidr_pkg::S_READ: begin
                cmd.rd_en = !sts.invalid;
            end
            mtidr_pkg::S_CHECK: begin
                if (insert_done) begin
                    cmd.insert_write = 1'b1;
                    cmd.emit         = mtidr_pkg::EMIT_INSERT;
                end else if (!check_stall) begin
                    cmd.idx_inc = !sts.idx_last;
                    if (!sts.is_insert && sts.key_hit) begin
                        cmd.apply   = 1'b1;
                        cmd.capture = report;
                        if (report && sts.pend_valid) begin
                            cmd.emit = mtidr_pkg::EMIT_MID;
                        end
                    end
                end
            end
            mtidr_pkg::S_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit = mtidr_pkg::EMIT_FINAL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtidr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/mtidr_dp.sv =====
// ----------------------------------------------------------------------------
// mtidr_dp: match table datapath
// Slot RAM with per-slot occupied bits, slot index, request registers, the
// pending-match register that resolves the last flag, and the output register.
// ----------------------------------------------------------------------------
module mtidr_dp #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [mtidr_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mtidr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast,
    input  mtidr_pkg::dp_cmd_t                    cmd,
    output mtidr_pkg::dp_status_t                 sts
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int KW    = mtidr_pkg::KEY_W;
    localparam int PW    = mtidr_pkg::POS_W;

    mtidr_pkg::req_t                req_reg;
    logic [KW-1:0]                  key_reg;
    logic [KW-1:0]                  nv_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic [TABLE_DEPTH-1:0]         occ_reg, occ_next;
    logic                           pend_valid_reg;
    logic [IDX_W-1:0]               pend_idx_reg;
    logic [KW-1:0]                  pend_value_reg;
    logic [mtidr_pkg::CNT_W-1:0]    cnt_reg;

    logic                           out_valid_reg;
    mtidr_pkg::status_t             out_status_reg, out_status_next;
    logic [PW-1:0]                  out_pos_reg, out_pos_next;
    logic [KW-1:0]                  out_value_reg, out_value_next;
    logic                           out_last_reg, out_last_next;

    logic [KW-1:0]                  rdata;
    logic                           ram_we;
    logic [KW-1:0]                  ram_wdata;
    logic [KW-1:0]                  hit_value;
    logic                           out_free;
    logic                           invalid;
    logic [IDX_W+PW-1:0]            idx_ext;
    logic [IDX_W+PW-1:0]            pend_ext;

    assign idx_ext  = {{PW{1'b0}}, idx_reg};
    assign pend_ext = {{PW{1'b0}}, pend_idx_reg};

    assign invalid  = (key_reg == '0) ||
                      (req_reg == mtidr_pkg::REQ_REPLACE && nv_reg == '0);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        case (req_reg)
            mtidr_pkg::REQ_DELETE:  hit_value = '0;
            mtidr_pkg::REQ_REPLACE: hit_value = nv_reg;
            default:                hit_value = rdata;
        endcase
    end

    // Deletion only drops the occupied bit; the stale RAM word is masked.
    assign ram_we    = cmd.insert_write || (cmd.apply && req_reg == mtidr_pkg::REQ_REPLACE);
    assign ram_wdata = cmd.insert_write ? key_reg : nv_reg;

    mtidr_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (cmd.rd_en),
        .addr  (idx_reg),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    always_comb begin
        sts.invalid    = invalid;
        sts.is_insert  = (req_reg == mtidr_pkg::REQ_INSERT);
        sts.slot_free  = !occ_reg[idx_reg];
        sts.key_hit    = occ_reg[idx_reg] && (rdata == key_reg);
        sts.pend_valid = pend_valid_reg;
        sts.cnt_full   = (cnt_reg == mtidr_pkg::CNT_W'(mtidr_pkg::MAX_RESULTS));
        sts.idx_last   = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        sts.out_free   = out_free;
    end

    always_comb begin
        occ_next = occ_reg;
        if (cmd.insert_write) begin
            occ_next[idx_reg] = 1'b1;
        end else if (cmd.apply && req_reg == mtidr_pkg::REQ_DELETE) begin
            occ_next[idx_reg] = 1'b0;
        end
    end

    always_comb begin
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        case (cmd.emit)
            mtidr_pkg::EMIT_INSERT: begin
                out_status_next = mtidr_pkg::ST_OK;
                out_pos_next    = idx_ext[PW-1:0];
                out_value_next  = key_reg;
                out_last_next   = 1'b1;
            end
            mtidr_pkg::EMIT_MID: begin
                out_status_next = mtidr_pkg::ST_OK;
                out_pos_next    = pend_ext[PW-1:0];
                out_value_next  = pend_value_reg;
                out_last_next   = 1'b0;
            end
            mtidr_pkg::EMIT_FINAL: begin
                out_pos_next   = '0;
                out_value_next = '0;
                out_last_next  = 1'b1;
                if (invalid) begin
                    out_status_next = mtidr_pkg::ST_INVALID;
                end else if (req_reg == mtidr_pkg::REQ_INSERT) begin
                    out_status_next = mtidr_pkg::ST_FULL;
                end else if (pend_valid_reg) begin
                    out_status_next = mtidr_pkg::ST_OK;
                    out_pos_next    = pend_ext[PW-1:0];
                    out_value_next  = pend_value_reg;
                end else begin
                    out_status_next = mtidr_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (cmd.load_req) begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end else begin
                if (cmd.idx_inc) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmd.capture) begin
                    pend_valid_reg <= 1'b1;
                    cnt_reg        <= cnt_reg + 1'b1;
                end
            end
            if (cmd.emit != mtidr_pkg::EMIT_NONE) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= mtidr_pkg::req_t'(s_tuser);
            key_reg <= s_tdata[KW-1:0];
            nv_reg  <= s_tdata[2*KW-1:KW];
        end
        if (cmd.capture) begin
            pend_idx_reg   <= idx_reg;
            pend_value_reg <= hit_value;
        end
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(mtidr_pkg::M_TDATA_W - KW - PW){1'b0}}, out_value_reg, out_pos_reg};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= mtidr_pkg::CNT_W'(mtidr_pkg::MAX_RESULTS))
        else $error("reported match count exceeds the result limit");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != mtidr_pkg::ST_OK |-> out_last_reg)
        else $error("error result not marked as last");

    a_mid_needs_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit == mtidr_pkg::EMIT_MID |-> pend_valid_reg && out_free)
        else $error("intermediate result emitted without a pending match");

    a_insert_sets_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert_write |=> occ_reg[$past(idx_reg)])
        else $error("inserted slot not marked occupied");

endmodule

// ===== src/match_table_insert_delete_replace.sv =====
// ----------------------------------------------------------------------------
// match_table_insert_delete_replace: small match table
// Insert, delete-all, replace-all and query over a table of positive values.
// ----------------------------------------------------------------------------
// A request on the slave stream (kind in s_tuser, key and new value in
// s_tdata) is taken only while the block is idle. The slots live in a
// single-port RAM and are visited one at a time (read, then compare and
// write); an insert stops at the first free slot and a rejected request
// skips the walk, which is held while the master side stalls the output.
// Delete, replace and
// query return one result per matching slot in ascending order (at most
// eight, the eighth carrying tlast) or one not-found result; insert returns
// one result. A finished result waits in the output register while the next
// request is accepted. Reset empties the table at once.
module match_table_insert_delete_replace #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mtidr_pkg::S_TDATA_W-1:0] s_tdata,  // key [30:0], new_value [61:31]
    input  logic [1:0]                      s_tuser,  // req_type [1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mtidr_pkg::M_TDATA_W-1:0] m_tdata,  // position [2:0], value [33:3]
    output logic [1:0]                      m_tuser,  // status [1:0]
    output logic                            m_tlast
);

    mtidr_pkg::dp_cmd_t    cmd;
    mtidr_pkg::dp_status_t sts;

    mtidr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtidr_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
